/* src/brp_pkg.sv */
package brp_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int HANDLE_BITS = 32;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    localparam int CFG_W      = 5;
    localparam int KIND_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int OUT_CNT_W  = 5;
    localparam int S_DATA_W   = ((HANDLE_BITS + 7) / 8) * 8;
    localparam int M_FIELDS_W = STATUS_W + HANDLE_BITS + 2 * OUT_CNT_W;
    localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_PAD_W    = M_DATA_W - M_FIELDS_W;

    localparam logic [KIND_W-1:0] KIND_ADD = 2'd0;
    localparam logic [KIND_W-1:0] KIND_OUT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_IN  = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NONE_FREE = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd3;

    // Microprogram step addresses.
    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] ST_IDLE  = 3'd0;
    localparam logic [STEP_W-1:0] ST_ADD   = 3'd1;
    localparam logic [STEP_W-1:0] ST_PRIME = 3'd2;
    localparam logic [STEP_W-1:0] ST_SCAN  = 3'd3;
    localparam logic [STEP_W-1:0] ST_EMIT  = 3'd4;

    // Datapath actions.
    localparam logic [2:0] ACT_LATCH = 3'd0;
    localparam logic [2:0] ACT_ADD   = 3'd1;
    localparam logic [2:0] ACT_PRIME = 3'd2;
    localparam logic [2:0] ACT_SCAN  = 3'd3;
    localparam logic [2:0] ACT_EMIT  = 3'd4;

    // Sequencing modes.
    localparam logic [1:0] SEQ_GOTO     = 2'd0;
    localparam logic [1:0] SEQ_DISPATCH = 2'd1;
    localparam logic [1:0] SEQ_LOOP     = 2'd2;
    localparam logic [1:0] SEQ_WAIT_OUT = 2'd3;

    typedef struct packed {
        logic [2:0]        act;
        logic [1:0]        seq;
        logic [STEP_W-1:0] next;
    } ucw_t;

    typedef struct packed {
        logic                   en;
        logic [IDX_W-1:0]       addr;
        logic [HANDLE_BITS-1:0] data;
    } tbl_wr_t;

    function automatic ucw_t ucode_rom(input logic [STEP_W-1:0] step);
        ucw_t w;
        begin
            unique case (step)
                ST_IDLE:  w = '{act: ACT_LATCH, seq: SEQ_DISPATCH, next: ST_IDLE};
                ST_ADD:   w = '{act: ACT_ADD,   seq: SEQ_GOTO,     next: ST_EMIT};
                ST_PRIME: w = '{act: ACT_PRIME, seq: SEQ_GOTO,     next: ST_SCAN};
                ST_SCAN:  w = '{act: ACT_SCAN,  seq: SEQ_LOOP,     next: ST_EMIT};
                ST_EMIT:  w = '{act: ACT_EMIT,  seq: SEQ_WAIT_OUT, next: ST_IDLE};
                default:  w = '{act: ACT_EMIT,  seq: SEQ_GOTO,     next: ST_IDLE};
            endcase
            return w;
        end
    endfunction

endpackage

/* src/brp_table.sv */
module brp_table (
    input  logic                              clk,
    input  brp_pkg::tbl_wr_t                  wr,
    input  logic [brp_pkg::IDX_W-1:0]         rd_addr,
    output logic [brp_pkg::HANDLE_BITS-1:0]   rd_data
);

    logic [brp_pkg::HANDLE_BITS-1:0] mem [brp_pkg::MAX_ENTRIES];
    logic [brp_pkg::HANDLE_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/bounded_resource_pool_core.sv */
// Add: an accepted input beat runs the ADD step, and the EMIT step then loads the result register;
// kind three goes straight to EMIT. Checkout and checkin run the PRIME step and then the SCAN step,
// a scan that reads one handle-table entry per cycle through the table's read port.
// A waiting result beat holds the last step; a new input beat is taken the cycle after the
// result is loaded, so the pool takes no new item before it is through with the last one.
// Reset (rst_n low, asynchronous) empties the pool, clears the free flags, sets pool_size to 16.
module bounded_resource_pool_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wen,
    input  logic [brp_pkg::CFG_W-1:0]       cfg_wdata,   // pool_size
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [brp_pkg::S_DATA_W-1:0]    s_tdata,     // resource_handle
    input  logic [brp_pkg::KIND_W-1:0]      s_tuser,     // kind
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // status, handle_out, free_count, added_count, zero padding
    output logic [brp_pkg::M_DATA_W-1:0]    m_tdata
);

    brp_pkg::ucw_t uw;

    logic [brp_pkg::STEP_W-1:0]      step_reg,      step_next;
    logic [brp_pkg::CNT_W-1:0]       idx_reg,       idx_next;
    logic [brp_pkg::CNT_W-1:0]       cmp_idx_reg,   cmp_idx_next;
    logic [brp_pkg::KIND_W-1:0]      kind_reg,      kind_next;
    logic [brp_pkg::HANDLE_BITS-1:0] handle_reg,    handle_next;
    logic [brp_pkg::STATUS_W-1:0]    status_reg,    status_next;
    logic [brp_pkg::HANDLE_BITS-1:0] hout_reg,      hout_next;
    logic [brp_pkg::MAX_ENTRIES-1:0] free_flags_reg, free_flags_next;
    logic [brp_pkg::CNT_W-1:0]       added_reg,     added_next;
    logic [brp_pkg::CNT_W-1:0]       free_reg,      free_next;
    logic [brp_pkg::CFG_W-1:0]       pool_size_reg;
    logic                            out_vld_reg,   out_vld_next;
    logic [brp_pkg::M_DATA_W-1:0]    out_data_reg,  out_data_next;

    brp_pkg::tbl_wr_t                tbl_wr;
    logic [brp_pkg::HANDLE_BITS-1:0] rd_data;
    logic [brp_pkg::CNT_W-1:0]       cap;
    logic [brp_pkg::IDX_W-1:0]       cmp_pos;
    logic                            in_beat;
    logic                            out_free;
    logic                            cmp_in_range;
    logic                            hit;
    logic                            scan_end;
    logic                            full;

    brp_table u_table (
        .clk     (clk),
        .wr      (tbl_wr),
        .rd_addr (idx_reg[brp_pkg::IDX_W-1:0]),
        .rd_data (rd_data)
    );

    assign uw       = brp_pkg::ucode_rom(step_reg);
    assign s_tready = (uw.seq == brp_pkg::SEQ_DISPATCH);
    assign in_beat  = s_tvalid & s_tready;
    assign out_free = !out_vld_reg || m_tready;
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

    // Out-of-range sizes are clamped to one and to the table depth.
    always_comb
    begin
        priority if (pool_size_reg == '0)
            cap = brp_pkg::CNT_W'(1);
        else if (32'(pool_size_reg) > brp_pkg::MAX_ENTRIES)
            cap = brp_pkg::CNT_W'(brp_pkg::MAX_ENTRIES);
        else
            cap = brp_pkg::CNT_W'(pool_size_reg);
    end

    assign full = (added_reg >= cap);

    // rd_data now holds the registered table read issued for the entry in cmp_idx_reg.
    assign cmp_pos      = cmp_idx_reg[brp_pkg::IDX_W-1:0];
    assign cmp_in_range = (cmp_idx_reg < added_reg);
    assign hit = cmp_in_range &&
                 ((kind_reg == brp_pkg::KIND_OUT) ? free_flags_reg[cmp_pos]
                  : ((rd_data == handle_reg) && !free_flags_reg[cmp_pos]));
    assign scan_end = !cmp_in_range || hit;

    // Sequencer.
    always_comb
    begin
        step_next = step_reg;
        unique case (uw.seq)
            brp_pkg::SEQ_GOTO:
            begin
                step_next = uw.next;
            end
            brp_pkg::SEQ_DISPATCH:
            begin
                if (in_beat)
                begin
                    unique case (s_tuser)
                        brp_pkg::KIND_ADD: step_next = brp_pkg::ST_ADD;
                        brp_pkg::KIND_OUT: step_next = brp_pkg::ST_PRIME;
                        brp_pkg::KIND_IN:  step_next = brp_pkg::ST_PRIME;
                        default:           step_next = brp_pkg::ST_EMIT;
                    endcase
                end
            end
            brp_pkg::SEQ_LOOP:
            begin
                if (scan_end)
                    step_next = uw.next;
            end
            brp_pkg::SEQ_WAIT_OUT:
            begin
                if (out_free)
                    step_next = uw.next;
            end
            default:
            begin
                step_next = brp_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath.
    always_comb
    begin
        idx_next        = idx_reg;
        cmp_idx_next    = cmp_idx_reg;
        kind_next       = kind_reg;
        handle_next     = handle_reg;
        status_next     = status_reg;
        hout_next       = hout_reg;
        free_flags_next = free_flags_reg;
        added_next      = added_reg;
        free_next       = free_reg;
        out_vld_next    = out_vld_reg && !m_tready;
        out_data_next   = out_data_reg;
        tbl_wr.en       = 1'b0;
        tbl_wr.addr     = added_reg[brp_pkg::IDX_W-1:0];
        tbl_wr.data     = handle_reg;

        unique case (uw.act)
            brp_pkg::ACT_LATCH:
            begin
                if (in_beat)
                begin
                    kind_next   = s_tuser;
                    handle_next = s_tdata[brp_pkg::HANDLE_BITS-1:0];
                    hout_next   = '0;
                    idx_next    = '0;
                    unique case (s_tuser)
                        brp_pkg::KIND_OUT: status_next = brp_pkg::STATUS_NONE_FREE;
                        brp_pkg::KIND_IN:  status_next = brp_pkg::STATUS_NOT_FOUND;
                        default:           status_next = brp_pkg::STATUS_OK;
                    endcase
                end
            end
            brp_pkg::ACT_ADD:
            begin
                if (full)
                begin
                    status_next = brp_pkg::STATUS_FULL;
                end
                else
                begin
                    tbl_wr.en = 1'b1;
                    free_flags_next[added_reg[brp_pkg::IDX_W-1:0]] = 1'b1;
                    added_next = added_reg + brp_pkg::CNT_W'(1);
                    free_next  = free_reg + brp_pkg::CNT_W'(1);
                end
            end
            brp_pkg::ACT_PRIME:
            begin
                cmp_idx_next = idx_reg;
                idx_next     = idx_reg + brp_pkg::CNT_W'(1);
            end
            brp_pkg::ACT_SCAN:
            begin
                if (hit)
                begin
                    status_next = brp_pkg::STATUS_OK;
                    if (kind_reg == brp_pkg::KIND_OUT)
                    begin
                        free_flags_next[cmp_pos] = 1'b0;
                        hout_next = rd_data;
                        if (free_reg != '0)
                            free_next = free_reg - brp_pkg::CNT_W'(1);
                    end
                    else
                    begin
                        free_flags_next[cmp_pos] = 1'b1;
                        free_next = free_reg + brp_pkg::CNT_W'(1);
                    end
                end
                else if (cmp_in_range)
                begin
                    cmp_idx_next = idx_reg;
                    idx_next     = idx_reg + brp_pkg::CNT_W'(1);
                end
            end
            brp_pkg::ACT_EMIT:
            begin
                if (out_free)
                begin
                    out_vld_next  = 1'b1;
                    out_data_next = {brp_pkg::M_PAD_W'(0),
                                     brp_pkg::OUT_CNT_W'(added_reg),
                                     brp_pkg::OUT_CNT_W'(free_reg),
                                     hout_reg,
                                     status_reg};
                end
            end
            default:
            begin
                out_vld_next = out_vld_reg && !m_tready;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg       <= brp_pkg::ST_IDLE;
            free_flags_reg <= '0;
            added_reg      <= '0;
            free_reg       <= '0;
            pool_size_reg  <= brp_pkg::CFG_W'(16);
            out_vld_reg    <= 1'b0;
        end
        else
        begin
            step_reg       <= step_next;
            free_flags_reg <= free_flags_next;
            added_reg      <= added_next;
            free_reg       <= free_next;
            out_vld_reg    <= out_vld_next;
            if (cfg_wen)
                pool_size_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        cmp_idx_reg  <= cmp_idx_next;
        kind_reg     <= kind_next;
        handle_reg   <= handle_next;
        status_reg   <= status_next;
        hout_reg     <= hout_next;
        out_data_reg <= out_data_next;
    end

endmodule

/* src/brp_checker.sv */
module brp_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [brp_pkg::M_DATA_W-1:0]  m_tdata
);

    // A stalled result beat keeps its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // Only one operation is in flight at a time.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second input beat taken while busy");

    // Free entries never outnumber added entries, and neither exceeds the depth.
    a_counts: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[38:34] <= m_tdata[43:39]) && (m_tdata[43:39] <= 5'd16))
        else $error("free or added count out of range");

    // Only a successful checkout returns a handle.
    a_handle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[1:0] != brp_pkg::STATUS_OK) |-> (m_tdata[33:2] == '0))
        else $error("handle returned with a failing status");

endmodule

bind bounded_resource_pool_core brp_checker u_brp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
